### src/johnson_trotter_permuter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the permuter
// Clocked property wrappers with an asynchronous, active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef JOHNSON_TROTTER_PERMUTER_ASSERT_SVH
`define JOHNSON_TROTTER_PERMUTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JTP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/jtp_pkg.sv
// ----------------------------------------------------------------------------
// jtp_pkg
// Shared types and fixed widths of the permutation stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package jtp_pkg;

	localparam int DATA_W = 16;
	localparam int POS_W  = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWAP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_init;
		logic scan;
		logic swap;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last_slot;
		logic found;
	} stat_t;

endpackage

`default_nettype wire

### src/johnson_trotter_permuter.sv
// ----------------------------------------------------------------------------
// johnson_trotter_permuter
// Steps a loaded list through its arrangements in minimal-change order.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   --------  ----------------------  ---------------------------------------
//   request   start, accepted if !busy mode, value, first
//   result    valid, one-cycle strobe element, position, last, done_res
//
// A load request never raises busy. An advance request over N loaded values
// keeps busy high through a scan of the slots, a swap state and an output pass
// over the N values; with nothing mobile it ends after the swap state. The
// single slot read port is shared by the search and the output stream, so they
// run one after the other. Results follow one per cycle, each registered in
// the cycle after the state that produces it. Reset is asynchronous and active
// low and empties the list. The receiver cannot stall, so results are never held.
//
`default_nettype none

module johnson_trotter_permuter #(
	parameter int MAX_ELEMENTS = 8,
	parameter int VALUE_BITS   = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        mode,
	input  wire logic [jtp_pkg::DATA_W-1:0]  value,
	input  wire logic                        first,
	output logic                             valid,
	output logic      [jtp_pkg::DATA_W-1:0]  element,
	output logic      [jtp_pkg::POS_W-1:0]   position,
	output logic                             last,
	output logic                             done_res
);

	jtp_pkg::cmd_t  cmd;
	jtp_pkg::stat_t stat;

	jtp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	jtp_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.VALUE_BITS   (VALUE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (value),
		.first    (first),
		.stat     (stat),
		.element  (element),
		.position (position),
		.last     (last),
		.done_res (done_res),
		.valid    (valid)
	);

endmodule

`default_nettype wire

### src/jtp_ctrl.sv
// ----------------------------------------------------------------------------
// jtp_ctrl
// Sequencer: loads in idle; scans, swaps, then streams the arrangement.
// ----------------------------------------------------------------------------
`default_nettype none

module jtp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          mode,
	input  wire jtp_pkg::stat_t stat,
	output jtp_pkg::cmd_t      cmd,
	output logic               busy
);

	jtp_pkg::state_t state_q;
	jtp_pkg::state_t state_d;
	logic            accept;

	assign accept = start && (state_q == jtp_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jtp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			jtp_pkg::ST_IDLE: begin
				if (accept && mode) begin
					state_d = jtp_pkg::ST_SCAN;
				end
			end
			jtp_pkg::ST_SCAN: begin
				if (stat.last_slot) begin
					state_d = jtp_pkg::ST_SWAP;
				end
			end
			jtp_pkg::ST_SWAP: begin
				// With nothing mobile the done result goes out from this state.
				state_d = stat.found ? jtp_pkg::ST_EMIT : jtp_pkg::ST_IDLE;
			end
			jtp_pkg::ST_EMIT: begin
				if (stat.last_slot) begin
					state_d = jtp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = jtp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			jtp_pkg::ST_IDLE: begin
				busy          = 1'b0;
				cmd.load      = accept && !mode;
				cmd.scan_init = accept && mode;
			end
			jtp_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			jtp_pkg::ST_SWAP: begin
				cmd.swap = 1'b1;
			end
			jtp_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

### src/jtp_datapath.sv
// ----------------------------------------------------------------------------
// jtp_datapath
// Slot store, mobility cells, largest-mobile search and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module jtp_datapath #(
	parameter int MAX_ELEMENTS = 8,
	parameter int VALUE_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire jtp_pkg::cmd_t                 cmd,
	input  wire logic [jtp_pkg::DATA_W-1:0]    value,
	input  wire logic                          first,
	output jtp_pkg::stat_t                     stat,
	output logic      [jtp_pkg::DATA_W-1:0]    element,
	output logic      [jtp_pkg::POS_W-1:0]     position,
	output logic                               last,
	output logic                               done_res,
	output logic                               valid
);

	localparam int IdxW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CntW = $clog2(MAX_ELEMENTS + 1);
	localparam int OutW = jtp_pkg::DATA_W;
	localparam int PosW = jtp_pkg::POS_W;

	logic [VALUE_BITS-1:0]   slot_v_q [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0] slot_left_q;
	logic [CntW-1:0]         count_q;
	logic [IdxW-1:0]         idx_q;
	logic                    found_q;
	logic [IdxW-1:0]         best_idx_q;
	logic [VALUE_BITS-1:0]   best_v_q;
	logic                    best_left_q;

	logic [OutW-1:0]         element_q;
	logic [PosW-1:0]         position_q;
	logic                    last_q;
	logic                    done_q;
	logic                    valid_q;

	logic [VALUE_BITS-1:0]   vin;
	logic [CntW-1:0]         base;
	logic                    wr_en;
	logic [VALUE_BITS-1:0]   rd_v;
	logic                    last_slot;
	logic                    rd_gt;
	logic                    do_swap;
	logic [IdxW-1:0]         pair_lo;
	logic [MAX_ELEMENTS-1:0] mobile;

	assign vin       = VALUE_BITS'(value);
	assign base      = first ? '0 : count_q;
	assign wr_en     = cmd.load && (base < CntW'(MAX_ELEMENTS));
	assign rd_v      = slot_v_q[idx_q];
	assign last_slot = (CntW'(idx_q) + CntW'(1)) >= count_q;
	assign rd_gt     = rd_v > best_v_q;
	assign do_swap   = cmd.swap && found_q;
	// Lower slot of the pair being exchanged.
	assign pair_lo   = best_left_q ? (best_idx_q - IdxW'(1)) : best_idx_q;

	assign stat.last_slot = last_slot;
	assign stat.found     = found_q;

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_slot
		logic                  left_lt;
		logic                  right_lt;
		logic                  take_right;
		logic                  take_left;
		logic [VALUE_BITS-1:0] v_right;
		logic [VALUE_BITS-1:0] v_left;
		logic                  d_right;
		logic                  d_left;

		if (i > 0) begin : g_lo
			assign left_lt   = slot_v_q[i-1] < slot_v_q[i];
			assign take_left = do_swap && (pair_lo == IdxW'(i - 1));
			assign v_left    = slot_v_q[i-1];
			assign d_left    = slot_left_q[i-1];
		end else begin : g_lo_none
			assign left_lt   = 1'b0;
			assign take_left = 1'b0;
			assign v_left    = slot_v_q[i];
			assign d_left    = slot_left_q[i];
		end

		if (i < MAX_ELEMENTS - 1) begin : g_hi
			assign right_lt   = slot_v_q[i+1] < slot_v_q[i];
			assign take_right = do_swap && (pair_lo == IdxW'(i));
			assign v_right    = slot_v_q[i+1];
			assign d_right    = slot_left_q[i+1];
		end else begin : g_hi_none
			assign right_lt   = 1'b0;
			assign take_right = 1'b0;
			assign v_right    = slot_v_q[i];
			assign d_right    = slot_left_q[i];
		end

		// A value is mobile when the loaded neighbour it faces is strictly smaller.
		assign mobile[i] = (CntW'(i) < count_q) &&
			(slot_left_q[i] ? left_lt : ((CntW'(i + 1) < count_q) && right_lt));

		always_ff @(posedge clk) begin
			if (wr_en && (base[IdxW-1:0] == IdxW'(i))) begin
				slot_v_q[i] <= vin;
			end else if (take_right) begin
				slot_v_q[i] <= v_right;
			end else if (take_left) begin
				slot_v_q[i] <= v_left;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				slot_left_q[i] <= 1'b1;
			end else if (cmd.load) begin
				slot_left_q[i] <= 1'b1;
			end else if (take_right) begin
				slot_left_q[i] <= d_right;
			end else if (take_left) begin
				slot_left_q[i] <= d_left;
			end else if (cmd.emit && (idx_q == IdxW'(i)) && rd_gt) begin
				// Values larger than the moved one turn round as they stream out.
				slot_left_q[i] <= !slot_left_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit || (cmd.swap && !found_q);
			if (cmd.load) begin
				count_q <= wr_en ? (base + CntW'(1)) : base;
			end
			if (cmd.scan_init) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + IdxW'(1);
				if (mobile[idx_q] && (!found_q || rd_gt)) begin
					found_q <= 1'b1;
				end
			end else if (cmd.swap) begin
				idx_q <= '0;
			end else if (cmd.emit) begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

	// Strict compare keeps the lowest position among equal largest values.
	always_ff @(posedge clk) begin
		if (cmd.scan && mobile[idx_q] && (!found_q || rd_gt)) begin
			best_idx_q  <= idx_q;
			best_v_q    <= rd_v;
			best_left_q <= slot_left_q[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.swap && !found_q) begin
			element_q  <= '0;
			position_q <= '0;
			last_q     <= 1'b1;
			done_q     <= 1'b1;
		end else if (cmd.emit) begin
			element_q  <= OutW'(rd_v);
			position_q <= PosW'(idx_q);
			last_q     <= last_slot;
			done_q     <= 1'b0;
		end
	end

	assign element  = element_q;
	assign position = position_q;
	assign last     = last_q;
	assign done_res = done_q;
	assign valid    = valid_q;

endmodule

`default_nettype wire

### src/jtp_checker.sv
// ----------------------------------------------------------------------------
// jtp_checker
// Port-level checks on request and result sequencing of the permuter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "johnson_trotter_permuter_assert.svh"

module jtp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        mode,
	input wire logic                        valid,
	input wire logic [jtp_pkg::DATA_W-1:0]  element,
	input wire logic [jtp_pkg::POS_W-1:0]   position,
	input wire logic                        last,
	input wire logic                        done_res
);

	`JTP_ASSERT_NEXT(a_adv_busy, clk, arst_n, start && !busy && mode, busy, "advance request did not raise busy")
	`JTP_ASSERT_NEXT(a_load_idle, clk, arst_n, start && !busy && !mode, !busy, "load request raised busy")
	`JTP_ASSERT_SAME(a_done_shape, clk, arst_n, valid && done_res, last && (element == '0) && (position == '0), "done result has wrong fields")
	`JTP_ASSERT_NEXT(a_run_contig, clk, arst_n, valid && !last, valid && !done_res, "result run broke before its last element")
	`JTP_ASSERT_NEXT(a_pos_step, clk, arst_n, valid && !last, position == ($past(position) + 3'd1), "result positions do not step by one")

endmodule

bind johnson_trotter_permuter jtp_checker u_jtp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.mode     (mode),
	.valid    (valid),
	.element  (element),
	.position (position),
	.last     (last),
	.done_res (done_res)
);

`default_nettype wire

### tb/sv/permutation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_checker
// Watches the request and result channels of the permuter, keeps its own
// copy of the list and directions, and checks every result in order.
// ----------------------------------------------------------------------------

package permuter_tb_pkg;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;

endpackage

module permutation_checker #(
	parameter int MAX_ELEMENTS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       busy,
	input  wire logic                       mode,
	input  wire logic [jtp_pkg::DATA_W-1:0] value,
	input  wire logic                       first,
	input  wire logic                       valid,
	input  wire logic [jtp_pkg::DATA_W-1:0] element,
	input  wire logic [jtp_pkg::POS_W-1:0]  position,
	input  wire logic                       last,
	input  wire logic                       done_res,
	output int                              fail_count,
	output int                              outstanding
);
	localparam int DATA_W = jtp_pkg::DATA_W;
	localparam int POS_W  = jtp_pkg::POS_W;

	typedef struct packed {
		logic [DATA_W-1:0] element;
		logic [POS_W-1:0]  position;
		logic              last;
		logic              done_res;
	} arrangement_entry_t;

	arrangement_entry_t expected_arrangement[$];

	logic [DATA_W-1:0] slot_val [MAX_ELEMENTS];
	bit                faces_left [MAX_ELEMENTS];
	int                list_len;

	// A value can move when the neighbour it faces exists and is strictly smaller.
	function automatic bit can_move(input int i);
		bit ok;
		ok = 1'b0;
		if (i < list_len) begin
			if (faces_left[i])
				ok = (i > 0) && (slot_val[i-1] < slot_val[i]);
			else
				ok = (i + 1 < list_len) && (slot_val[i+1] < slot_val[i]);
		end
		return ok;
	endfunction

	task automatic step_permutation(input logic m, input logic [DATA_W-1:0] v,
			input logic f);
		int                 best;
		int                 other;
		bit                 found;
		bit                 tmp_dir;
		logic [DATA_W-1:0]  moved;
		logic [DATA_W-1:0]  tmp_val;
		arrangement_entry_t entry;
		found = 1'b0;
		best  = 0;
		if (m == permuter_tb_pkg::MODE_LOAD) begin
			if (f)
				list_len = 0;
			if (list_len < MAX_ELEMENTS) begin
				slot_val[list_len] = v;
				list_len++;
			end
			foreach (faces_left[i])
				faces_left[i] = 1'b1;
		end else begin
			// Ties between equal largest values go to the lowest position.
			for (int i = 0; i < list_len; i++) begin
				if (can_move(i) && (!found || slot_val[i] > slot_val[best])) begin
					best  = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				entry.element  = '0;
				entry.position = '0;
				entry.last     = 1'b1;
				entry.done_res = 1'b1;
				expected_arrangement.insert(expected_arrangement.size(), entry);
			end else begin
				moved   = slot_val[best];
				other   = faces_left[best] ? best - 1 : best + 1;
				tmp_val = slot_val[best];
				tmp_dir = faces_left[best];
				slot_val[best]    = slot_val[other];
				faces_left[best]  = faces_left[other];
				slot_val[other]   = tmp_val;
				faces_left[other] = tmp_dir;
				for (int i = 0; i < list_len; i++)
					if (slot_val[i] > moved)
						faces_left[i] = !faces_left[i];
				for (int i = 0; i < list_len; i++) begin
					entry.element  = slot_val[i];
					entry.position = i[POS_W-1:0];
					entry.last     = (i + 1 == list_len);
					entry.done_res = 1'b0;
					expected_arrangement.insert(expected_arrangement.size(), entry);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		arrangement_entry_t exp_entry;
		if (!arst_n) begin
			list_len = 0;
			foreach (slot_val[i]) begin
				slot_val[i]   = '0;
				faces_left[i] = 1'b1;
			end
			expected_arrangement.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (valid) begin
				if (expected_arrangement.size() == 0) begin
					$error("unexpected result: element %0d position %0d last %0b done_res %0b",
						element, position, last, done_res);
					fail_count++;
				end else begin
					exp_entry = expected_arrangement.pop_front();
					if (element !== exp_entry.element) begin
						$error("element: expected %0d, got %0d", exp_entry.element, element);
						fail_count++;
					end
					if (position !== exp_entry.position) begin
						$error("position: expected %0d, got %0d", exp_entry.position, position);
						fail_count++;
					end
					if (last !== exp_entry.last) begin
						$error("last: expected %0b, got %0b", exp_entry.last, last);
						fail_count++;
					end
					if (done_res !== exp_entry.done_res) begin
						$error("done_res: expected %0b, got %0b", exp_entry.done_res, done_res);
						fail_count++;
					end
				end
			end
			// The request is modelled at the edge that accepts it.
			if (start && !busy)
				step_permutation(mode, value, first);
			outstanding = expected_arrangement.size();
		end
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and advance requests into the permuter in random bursts: a
// directed opening, then mostly sorted lists stepped through their orderings,
// mixed with unsorted, repeated, overflowing and stray requests.
// ----------------------------------------------------------------------------

module testbench;

	localparam int MAX_ELEMENTS  = 8;
	localparam int RANDOM_ITEMS  = 480;
	localparam int SETTLE_CYCLES = 2 * MAX_ELEMENTS + 8;
	localparam int DATA_W        = jtp_pkg::DATA_W;
	localparam int POS_W         = jtp_pkg::POS_W;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	logic              mode   = 1'b0;
	logic [DATA_W-1:0] value  = '0;
	logic              first  = 1'b0;
	logic              busy;
	logic              valid;
	logic [DATA_W-1:0] element;
	logic [POS_W-1:0]  position;
	logic              last;
	logic              done_res;
	int                fail_count;
	int                outstanding;

	int requests_sent = 0;
	int burst_left    = 1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	johnson_trotter_permuter #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.VALUE_BITS  (DATA_W)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.mode    (mode),
		.value   (value),
		.first   (first),
		.valid   (valid),
		.element (element),
		.position(position),
		.last    (last),
		.done_res(done_res)
	);

	permutation_checker #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.value      (value),
		.first      (first),
		.valid      (valid),
		.element    (element),
		.position   (position),
		.last       (last),
		.done_res   (done_res),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	// Holds one request on the bus until accepted, then perhaps closes the burst.
	task automatic send_request(input logic m, input logic [DATA_W-1:0] v, input logic f);
		int gap;
		start <= 1'b1;
		mode  <= m;
		value <= v;
		first <= f;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
			repeat (gap)
				@(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
	endtask

	task automatic advance_times(input int count);
		for (int i = 0; i < count; i++)
			send_request(permuter_tb_pkg::MODE_ADVANCE, DATA_W'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)));
	endtask

	// Loads n distinct values in ascending order, starting a fresh list.
	task automatic load_ascending(input int n);
		logic [DATA_W-1:0] vals [MAX_ELEMENTS];
		logic [DATA_W-1:0] cand;
		logic [DATA_W-1:0] tmp;
		bit                dup;
		for (int i = 0; i < n; i++) begin
			do begin
				cand = DATA_W'($urandom_range(0, 65535));
				dup  = 1'b0;
				for (int j = 0; j < i; j++)
					if (vals[j] == cand)
						dup = 1'b1;
			end while (dup);
			vals[i] = cand;
			for (int j = i; j > 0; j--) begin
				if (vals[j-1] > vals[j]) begin
					tmp       = vals[j];
					vals[j]   = vals[j-1];
					vals[j-1] = tmp;
				end
			end
		end
		for (int i = 0; i < n; i++)
			send_request(permuter_tb_pkg::MODE_LOAD, vals[i], i == 0);
	endtask

	initial begin
		int n;
		int r;
		int directed_sent;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Advancing an empty list, then a single value, both give the done result.
		send_request(permuter_tb_pkg::MODE_ADVANCE, 16'hFFFF, 1'b1);
		send_request(permuter_tb_pkg::MODE_LOAD, 16'hFFFF, 1'b1);
		send_request(permuter_tb_pkg::MODE_ADVANCE, 16'h0000, 1'b0);

		// Two extreme values: one swap, then done, and done again after that.
		send_request(permuter_tb_pkg::MODE_LOAD, 16'h0000, 1'b1);
		send_request(permuter_tb_pkg::MODE_LOAD, 16'hFFFF, 1'b0);
		advance_times(3);

		// A full list of eight; the ninth load is dropped.
		for (int i = 0; i < MAX_ELEMENTS + 1; i++)
			send_request(permuter_tb_pkg::MODE_LOAD,
				(i == MAX_ELEMENTS) ? 16'hAAAA : DATA_W'(i * 8191), i == 0);
		advance_times(2);

		// Repeated and unsorted values.
		send_request(permuter_tb_pkg::MODE_LOAD, 16'd5, 1'b1);
		send_request(permuter_tb_pkg::MODE_LOAD, 16'd5, 1'b0);
		send_request(permuter_tb_pkg::MODE_LOAD, 16'd3, 1'b0);
		send_request(permuter_tb_pkg::MODE_LOAD, 16'd5, 1'b0);
		advance_times(2);
		directed_sent = requests_sent;

		while (requests_sent < directed_sent + RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				r = $urandom_range(0, 9);
				n = (r < 7) ? $urandom_range(2, 4) : (r < 9) ? $urandom_range(5, 7) : 8;
				load_ascending(n);
				// Short lists are often stepped right through to the done result.
				if (n <= 4)
					advance_times($urandom_range(1, ((n == 2) ? 2 : (n == 3) ? 6 : 24) + 2));
				else
					advance_times($urandom_range(1, 20));
			end else if (r < 85) begin
				n = $urandom_range(1, MAX_ELEMENTS + 2);
				r = $urandom_range(0, 1);
				for (int i = 0; i < n; i++)
					send_request(permuter_tb_pkg::MODE_LOAD,
						r ? DATA_W'($urandom_range(0, 3)) : DATA_W'($urandom_range(0, 65535)),
						(i == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
				advance_times($urandom_range(1, 8));
			end else if (r < 92) begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					send_request(permuter_tb_pkg::MODE_LOAD, DATA_W'($urandom_range(0, 65535)),
						1'b0);
				advance_times($urandom_range(1, 4));
			end else begin
				advance_times($urandom_range(1, 3));
			end
		end
		start <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### johnson_trotter_permuter.f
+incdir+src
src/jtp_pkg.sv
src/jtp_ctrl.sv
src/jtp_datapath.sv
src/johnson_trotter_permuter.sv
src/jtp_checker.sv
tb/sv/permutation_checker.sv
tb/sv/testbench.sv
